@@ src/mep_pkg.sv @@
package mep_pkg;

	// pixel index and coordinate format
	localparam int INDEX_BITS    = 14;
	localparam int FRACTION_BITS = 26;
	localparam int COORD_W       = 32;
	localparam int STEP_W        = FRACTION_BITS + 1;
	localparam int ITER_W        = 13;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	// multiplier and datapath widths
	localparam int PROD_W  = 2 * COORD_W;
	localparam int SQ_W    = PROD_W - FRACTION_BITS;
	localparam int SUM_W   = SQ_W + 1;
	localparam int WIDE_W  = SQ_W + 2;
	localparam int C_W     = INDEX_BITS + STEP_W + 2;
	localparam int SAT_W   = (C_W > WIDE_W) ? C_W : WIDE_W;
	localparam int ABS_W   = COORD_W + 2;

	// escape radius squared, 4.0 in the square format
	localparam logic [SUM_W-1:0] ESCAPE_LIMIT = SUM_W'(4) << FRACTION_BITS;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;

	// register reset values: -2.5, -2.0, 2^-12, 2^-12 and 256
	localparam logic [COORD_W-1:0] RST_ORIGIN_REAL = COORD_W'(-167772160);
	localparam logic [COORD_W-1:0] RST_ORIGIN_IMAG = COORD_W'(-134217728);
	localparam logic [STEP_W-1:0]  RST_STEP        = STEP_W'(16384);
	localparam logic [ITER_W-1:0]  RST_MAX_ITER    = ITER_W'(256);

	// clamp a wide signed value into the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
		logic                       neg;
		logic [SAT_W-COORD_W-1:0]   upper;
		logic signed [COORD_W-1:0]  res;
		neg   = v[SAT_W-1];
		upper = v[SAT_W-2:COORD_W-1];
		if (!neg && (|upper)) begin
			res = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (neg && !(&upper)) begin
			res = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			res = v[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

@@ src/mandelbrot_escape_pixel.sv @@
// Mandelbrot escape-time pixel unit. Each word on the input channel names one pixel by
// column and row; the unit forms c = origin + index * step in signed Q6.26, forces the
// imaginary part to zero when it lies within half a row step of the axis, and iterates
// z = z*z + c from zero until |z|^2 reaches 4 or the count reaches max_iter. One 32x32
// signed multiplier with a registered product is shared by the setup and by all three
// products of an iteration, which steps through the check, update, square-x and square-y
// states. The next pixel can be taken once the result word has been loaded into the
// output register. in_stall is high while a pixel is in work; a finished result waits
// in the output register while the next pixel is taken. The configuration port is
// always ready; the user is to write it only while the unit is idle, which the unit
// itself does not enforce.
module mandelbrot_escape_pixel import mep_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [INDEX_BITS-1:0] col_index,
	input  logic [INDEX_BITS-1:0] row_index,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic [ITER_W-1:0]     iter_count,
	output logic                  interior,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CX   = 4'd1;
	localparam logic [3:0] S_CY   = 4'd2;
	localparam logic [3:0] S_CYS  = 4'd3;
	localparam logic [3:0] S_SNAP = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_UPD  = 4'd6;
	localparam logic [3:0] S_SQX  = 4'd7;
	localparam logic [3:0] S_SQY  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]                 state_q;

	// configuration registers
	logic signed [COORD_W-1:0]  origin_real_q;
	logic signed [COORD_W-1:0]  origin_imag_q;
	logic [STEP_W-1:0]          step_real_q;
	logic [STEP_W-1:0]          step_imag_q;
	logic [ITER_W-1:0]          max_iter_q;

	// working registers
	logic [INDEX_BITS-1:0]      col_q;
	logic [INDEX_BITS-1:0]      row_q;
	logic signed [COORD_W-1:0]  cx_q;
	logic signed [COORD_W-1:0]  cy_q;
	logic signed [COORD_W-1:0]  zx_q;
	logic signed [COORD_W-1:0]  zy_q;
	logic [SQ_W-1:0]            zx2_q;
	logic [SQ_W-1:0]            zy2_q;
	logic [ITER_W-1:0]          count_q;
	logic signed [PROD_W-1:0]   prod_q;

	// output register
	logic                       out_valid_q;
	logic [7:0]                 red_q;
	logic [7:0]                 green_q;
	logic [7:0]                 blue_q;
	logic [ITER_W-1:0]          iter_q;
	logic                       interior_q;

	// datapath nets
	logic signed [COORD_W-1:0]  mul_a;
	logic signed [COORD_W-1:0]  mul_b;
	logic signed [C_W-1:0]      c_sum;
	logic signed [COORD_W-1:0]  c_sat;
	logic [ABS_W-1:0]           cy_abs2;
	logic                       cy_snap;
	logic [SQ_W-1:0]            sq_new;
	logic [SUM_W-1:0]           mag2;
	logic                       keep_going;
	logic signed [WIDE_W-1:0]   nzx;
	logic signed [WIDE_W-1:0]   nzy;
	logic signed [PROD_W-1:0]   xy_shift;
	logic [ITER_W-1:0]          remain;
	logic                       done_fire;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_CX: begin
				mul_a = COORD_W'(col_q);
				mul_b = COORD_W'(step_real_q);
			end
			S_CY: begin
				mul_a = COORD_W'(row_q);
				mul_b = COORD_W'(step_imag_q);
			end
			S_CHK: begin
				mul_a = zx_q;
				mul_b = zy_q;
			end
			S_SQX: begin
				mul_a = zx_q;
				mul_b = zx_q;
			end
			S_SQY: begin
				mul_a = zy_q;
				mul_b = zy_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register, cleared naturally by zero operands in idle states
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// origin plus index times step, clamped
	always_comb begin
		if (state_q == S_CY) begin
			c_sum = C_W'(origin_real_q) + prod_q[C_W-1:0];
		end else begin
			c_sum = C_W'(origin_imag_q) + prod_q[C_W-1:0];
		end
		c_sat = sat_coord(SAT_W'(c_sum));
	end

	// snap near-axis rows onto the real axis
	always_comb begin
		if (cy_q[COORD_W-1]) begin
			cy_abs2 = (-ABS_W'(cy_q)) << 1;
		end else begin
			cy_abs2 = ABS_W'(cy_q) << 1;
		end
		cy_snap = (cy_abs2 < ABS_W'(step_imag_q));
	end

	// loop test on the fresh square of zy
	assign sq_new     = prod_q[PROD_W-1:FRACTION_BITS];
	assign mag2       = SUM_W'(zx2_q) + SUM_W'(sq_new);
	assign keep_going = (count_q < max_iter_q) && (mag2 < ESCAPE_LIMIT);

	// next z from the registered cross product and squares
	assign xy_shift = prod_q >>> (FRACTION_BITS - 1);
	assign nzy = xy_shift[WIDE_W-1:0] + WIDE_W'(cy_q);
	assign nzx = $signed(WIDE_W'(zx2_q)) - $signed(WIDE_W'(zy2_q)) + WIDE_W'(cx_q);

	// result colors from the remaining count
	assign remain    = max_iter_q - count_q;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q <= RST_ORIGIN_REAL;
			origin_imag_q <= RST_ORIGIN_IMAG;
			step_real_q   <= RST_STEP;
			step_imag_q   <= RST_STEP;
			max_iter_q    <= RST_MAX_ITER;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_REAL: origin_real_q <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_IMAG: origin_imag_q <= cfg_data[COORD_W-1:0];
				REG_STEP_REAL:   step_real_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_IMAG:   step_imag_q   <= cfg_data[STEP_W-1:0];
				REG_MAX_ITER:    max_iter_q    <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CX;
				S_CX:   state_q <= S_CY;
				S_CY:   state_q <= S_CYS;
				S_CYS:  state_q <= S_SNAP;
				S_SNAP: state_q <= S_CHK;
				S_CHK:  state_q <= keep_going ? S_UPD : S_DONE;
				S_UPD:  state_q <= S_SQX;
				S_SQX:  state_q <= S_SQY;
				S_SQY:  state_q <= S_CHK;
				S_DONE: if (done_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				col_q <= col_index;
				row_q <= row_index;
			end
			S_CY:  cx_q <= c_sat;
			S_CYS: cy_q <= c_sat;
			S_SNAP: begin
				if (cy_snap) cy_q <= '0;
				zx_q    <= '0;
				zy_q    <= '0;
				zx2_q   <= '0;
				count_q <= '0;
			end
			S_CHK: zy2_q <= sq_new;
			S_UPD: begin
				zx_q    <= sat_coord(SAT_W'(nzx));
				zy_q    <= sat_coord(SAT_W'(nzy));
				count_q <= count_q + 1'b1;
			end
			S_SQY: zx2_q <= sq_new;
			default: ;
		endcase
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (done_fire) begin
			iter_q <= count_q;
			if (count_q == max_iter_q) begin
				red_q      <= '0;
				green_q    <= '0;
				blue_q     <= '0;
				interior_q <= 1'b1;
			end else begin
				red_q      <= 8'(remain[2:0] * 8'd63);
				green_q    <= 8'(remain[1:0] * 8'd127);
				blue_q     <= {8{remain[0]}};
				interior_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;
	assign iter_count = iter_q;
	assign interior   = interior_q;

endmodule

@@ test/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mep_pkg::*;

	localparam longint Q_ONE          = longint'(1) << FRACTION_BITS;
	localparam longint COORD_MAX      = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_MIN      = -(longint'(1) << (COORD_W - 1));
	localparam int     WATCHDOG_LIMIT = 100000;
	localparam int     MAX_REPORTS    = 10;

	// one pixel result word
	typedef struct packed {
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [ITER_W-1:0] iters;
		logic              interior;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [INDEX_BITS-1:0] col_index;
	logic [INDEX_BITS-1:0] row_index;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic [ITER_W-1:0]     iter_count;
	logic                  interior;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// view registers as the unit should hold them
	longint      view_or;
	longint      view_oi;
	longint      view_sr;
	longint      view_si;
	int unsigned view_limit;

	pixel_t pending_pixels[$];
	int     fail_count;
	int     quiet_cycles;
	bit     src_gaps_on;
	bit     sink_gaps_on;

	mandelbrot_escape_pixel dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.col_index  (col_index),
		.row_index  (row_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.iter_count (iter_count),
		.interior   (interior),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_MAX) begin
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			return COORD_MIN;
		end
		return v;
	endfunction

	// escape-time iteration and coloring for one pixel
	function automatic pixel_t escape_color(input logic [INDEX_BITS-1:0] col,
			input logic [INDEX_BITS-1:0] row);
		longint      cx, cy, zx, zy, zx2, zy2, next_x, next_y, sq_limit;
		int unsigned steps, rem;
		pixel_t      px;
		sq_limit = longint'(4) << FRACTION_BITS;
		cx = clamp_coord(view_or + longint'(col) * view_sr);
		cy = clamp_coord(view_oi + longint'(row) * view_si);
		// points within half a row step of the real axis sit on it
		if (2 * (cy < 0 ? -cy : cy) < view_si) begin
			cy = 0;
		end
		zx = 0;
		zy = 0;
		zx2 = 0;
		zy2 = 0;
		steps = 0;
		while (steps < view_limit && zx2 + zy2 < sq_limit) begin
			next_y = ((zx * zy) >>> (FRACTION_BITS - 1)) + cy;
			next_x = zx2 - zy2 + cx;
			zy = clamp_coord(next_y);
			zx = clamp_coord(next_x);
			zx2 = (zx * zx) >>> FRACTION_BITS;
			zy2 = (zy * zy) >>> FRACTION_BITS;
			steps++;
		end
		px.iters = ITER_W'(steps);
		if (steps == view_limit) begin
			px.red = 8'd0;
			px.green = 8'd0;
			px.blue = 8'd0;
			px.interior = 1'b1;
		end else begin
			rem = view_limit - steps;
			px.red = 8'((rem % 8) * 63);
			px.green = 8'((rem % 4) * 127);
			px.blue = (rem % 2 != 0) ? 8'd255 : 8'd0;
			px.interior = 1'b0;
		end
		return px;
	endfunction

	// result side stalls at random
	always @(negedge clk) begin
		out_stall <= sink_gaps_on && ($urandom_range(0, 99) < 27);
	end

	// compare each result word with the oldest pending pixel
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{red, green, blue, iter_count, interior};
			if (pending_pixels.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("result word with nothing pending: r=%0d g=%0d b=%0d iters=%0d int=%0d",
						got.red, got.green, got.blue, got.iters, got.interior);
				end
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("pixel mismatch: expected r=%0d g=%0d b=%0d iters=%0d int=%0d",
							want.red, want.green, want.blue, want.iters, want.interior);
						$display("                got      r=%0d g=%0d b=%0d iters=%0d int=%0d",
							got.red, got.green, got.blue, got.iters, got.interior);
					end
				end
			end
		end
	end

	// give up when no word moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// present one pixel word, leave valid high on return
	task automatic send_pixel(input int unsigned col, input int unsigned row);
		while (src_gaps_on && $urandom_range(0, 99) < 27) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		col_index = INDEX_BITS'(col);
		row_index = INDEX_BITS'(row);
		do @(posedge clk); while (in_stall);
		pending_pixels.push_back(escape_color(col_index, row_index));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_pixels.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// one register write, valid left high for the next one
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ORIGIN_REAL: view_or = longint'($signed(data));
			REG_ORIGIN_IMAG: view_oi = longint'($signed(data));
			REG_STEP_REAL:   view_sr = longint'(data[STEP_W-1:0]);
			REG_STEP_IMAG:   view_si = longint'(data[STEP_W-1:0]);
			REG_MAX_ITER:    view_limit = int'(data[ITER_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// reprogram the whole view once the unit is idle
	task automatic load_view(input logic [CFG_DATA_W-1:0] o_re, input logic [CFG_DATA_W-1:0] o_im,
			input logic [CFG_DATA_W-1:0] s_re, input logic [CFG_DATA_W-1:0] s_im,
			input logic [CFG_DATA_W-1:0] limit);
		drain_results();
		cfg_write(REG_ORIGIN_REAL, o_re);
		cfg_write(REG_ORIGIN_IMAG, o_im);
		cfg_write(REG_STEP_REAL, s_re);
		cfg_write(REG_STEP_IMAG, s_im);
		cfg_write(REG_MAX_ITER, limit);
		cfg_valid = 1'b0;
	endtask

	// reset view: corners, axis points, interior and cusp
	task automatic test_reset_view();
		send_pixel(0, 0);
		send_pixel(16383, 16383);
		send_pixel(10240, 8192);
		send_pixel(6144, 8192);
		send_pixel(2048, 8192);
		send_pixel(11264, 8192);
		send_pixel(8192, 12288);
		send_pixel(16383, 0);
	endtask

	// rows just inside and just outside half a step from the axis
	task automatic test_antenna_snap();
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG + 32'd4096, RST_STEP, RST_STEP, RST_MAX_ITER);
		send_pixel(3072, 8192);
		send_pixel(3072, 8191);
		send_pixel(3072, 8193);
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG + 32'd8192, RST_STEP, RST_STEP, RST_MAX_ITER);
		send_pixel(3072, 8192);
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG + 32'd8191, RST_STEP, RST_STEP, RST_MAX_ITER);
		send_pixel(3072, 8192);
	endtask

	// zero, one and 4096 as the iteration limit
	task automatic test_iteration_limits();
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, RST_STEP, RST_STEP, 32'd0);
		send_pixel(10240, 8192);
		send_pixel(0, 0);
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, RST_STEP, RST_STEP, 32'd1);
		send_pixel(10240, 8192);
		send_pixel(0, 0);
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, RST_STEP, RST_STEP, 32'd4096);
		send_pixel(10240, 8192);
		send_pixel(0, 0);
	endtask

	// origins at both limits, steps of one and zero; c saturates high and sits at the low limit
	task automatic test_coordinate_extremes();
		load_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'(Q_ONE), 32'(Q_ONE), 32'd16);
		send_pixel(16383, 16383);
		send_pixel(0, 0);
		load_view(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 32'd16);
		send_pixel(16383, 16383);
		send_pixel(0, 0);
	endtask

	task automatic test_default_view();
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, RST_STEP, RST_STEP, RST_MAX_ITER);
		for (int i = 0; i < 100; i++) begin
			send_pixel($urandom_range(0, 16383), $urandom_range(0, 16383));
		end
	endtask

	// zoomed windows around random centers of interest
	task automatic test_zoom_windows();
		int unsigned span, step_re, step_im;
		longint      ctr_re, ctr_im;
		for (int w = 0; w < 4; w++) begin
			span = (1 << $urandom_range(6, 14)) - 1;
			step_re = $urandom_range(1, 32'(3 * Q_ONE) / span);
			step_im = ($urandom_range(0, 1) != 0) ? step_re
				: $urandom_range(1, 32'(3 * Q_ONE) / span);
			ctr_re = longint'($urandom_range(0, 32'(5 * Q_ONE / 2))) - 2 * Q_ONE;
			ctr_im = longint'($urandom_range(0, 32'(5 * Q_ONE / 2))) - 5 * Q_ONE / 4;
			load_view(32'(ctr_re - longint'(step_re) * span / 2),
				32'(ctr_im - longint'(step_im) * span / 2),
				step_re, step_im, $urandom_range(16, 256));
			for (int i = 0; i < 60; i++) begin
				// hold the sender until the unit has emptied once
				if (w == 1 && i == 30) begin
					drain_results();
				end
				send_pixel($urandom_range(0, span), $urandom_range(0, span));
			end
		end
	endtask

	// arbitrary register contents
	task automatic test_wild_settings();
		for (int w = 0; w < 3; w++) begin
			load_view($urandom, $urandom, $urandom_range(0, 32'(Q_ONE)),
				$urandom_range(0, 32'(Q_ONE)), $urandom_range(0, 64));
			for (int i = 0; i < 40; i++) begin
				send_pixel($urandom_range(0, 16383), $urandom_range(0, 16383));
			end
		end
	endtask

	// no gaps on either side
	task automatic test_back_to_back();
		src_gaps_on = 1'b0;
		sink_gaps_on = 1'b0;
		load_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, RST_STEP, RST_STEP, 32'd24);
		for (int i = 0; i < 100; i++) begin
			send_pixel($urandom_range(0, 16383), $urandom_range(0, 16383));
		end
		drain_results();
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		col_index = '0;
		row_index = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		quiet_cycles = 0;
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
		view_or = longint'($signed(RST_ORIGIN_REAL));
		view_oi = longint'($signed(RST_ORIGIN_IMAG));
		view_sr = longint'(RST_STEP);
		view_si = longint'(RST_STEP);
		view_limit = int'(RST_MAX_ITER);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_view();
		test_antenna_snap();
		test_iteration_limits();
		test_coordinate_extremes();
		test_default_view();
		test_zoom_windows();
		test_wild_settings();
		test_back_to_back();

		drain_results();
		repeat (64) @(negedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
